@@ src/spectrum_log_band_bar_meter_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Spectrum log band bar meter: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SPECTRUM_LOG_BAND_BAR_METER_UNIT_DEFINES_SVH
`define SPECTRUM_LOG_BAND_BAR_METER_UNIT_DEFINES_SVH

// same-cycle implication
`define SLBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/slbm_pkg.sv @@
// ---------------------------------------------------------------------------
// Spectrum log band bar meter: package
// Word types, register codes, widths and the bar column helper.
// ---------------------------------------------------------------------------
package slbm_pkg;

    localparam int MAG_W      = 24;
    localparam int START_W    = 23;
    localparam int CENTER_W   = 24;
    localparam int RATIO_W    = 16;
    localparam int FLOOR_W    = 24;
    localparam int DIV_W      = 24;
    localparam int SUM_W      = 34;
    localparam int BIN_W      = 10;
    localparam int EDGE_W     = 10;
    localparam int PROD_W     = CENTER_W + RATIO_W;
    localparam int RATIO_FRAC = 12;
    localparam int EDGE_SHIFT = 15;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int BAR_HEIGHT = 8;
    localparam int RED_ROWS   = 4 * BAR_HEIGHT / 8;
    localparam int GREEN_SKIP = 1 * BAR_HEIGHT / 8;
    localparam int IN_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH = 4;

    localparam logic [BIN_W-1:0]  COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [3:0]        MAX_RES   = 4'd8;
    localparam logic [3:0]        H_MAX     = 4'(BAR_HEIGHT);

    localparam logic [START_W-1:0] RST_START_CENTER = 23'd30427;
    localparam logic [RATIO_W-1:0] RST_BAND_RATIO   = 16'd9013;
    localparam logic [FLOOR_W-1:0] RST_NOISE_FLOOR  = 24'd10;
    localparam logic [DIV_W-1:0]   RST_AMP_DIVISOR  = 24'd1000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_CENTER = 2'd0,
        CFG_BAND_RATIO   = 2'd1,
        CFG_NOISE_FLOOR  = 2'd2,
        CFG_AMP_DIVISOR  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last_bin;
    } t_in_word;

    typedef struct packed {
        logic [2:0] band;
        logic [3:0] height;
        logic [7:0] red_column;
        logic [7:0] green_column;
        logic       last_band;
    } t_out_word;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last_bin;
        logic [BIN_W-1:0] bin_num;
        logic             add_ok;
    } t_item;

    // rows 8-h..7 lit
    function automatic logic [7:0] lit_rows(logic [3:0] h);
        logic [15:0] v_sh;
        v_sh = 16'h00FF << (H_MAX - h);
        return v_sh[7:0];
    endfunction

endpackage

@@ src/slbm_fifo.sv @@
// ---------------------------------------------------------------------------
// Spectrum log band bar meter: word queue
// Small register queue with valid/ready on both sides.
// ---------------------------------------------------------------------------
module slbm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ src/slbm_front.sv @@
// ---------------------------------------------------------------------------
// Spectrum log band bar meter: front end
// Numbers incoming bins, flags summable ones and queues them for the back end.
// ---------------------------------------------------------------------------
module slbm_front #(
    parameter int FFT_SIZE = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  slbm_pkg::t_in_word           i_in_word,
    input  logic [slbm_pkg::FLOOR_W-1:0] i_noise_floor,
    output logic                         o_item_valid,
    input  logic                         i_item_ready,
    output slbm_pkg::t_item              o_item
);

    localparam int USABLE_BINS = FFT_SIZE / 2 - 1;

    logic [slbm_pkg::BIN_W-1:0] r_bin_cnt;
    logic                       w_accept;
    slbm_pkg::t_item            w_item;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_item.magnitude = i_in_word.magnitude;
        w_item.last_bin  = i_in_word.last_bin;
        w_item.bin_num   = r_bin_cnt;
        w_item.add_ok    = (r_bin_cnt != '0) && (32'(r_bin_cnt) < USABLE_BINS)
                           && (i_in_word.magnitude > i_noise_floor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
        end else if (w_accept) begin
            if (i_in_word.last_bin) begin
                r_bin_cnt <= '0;
            end else if (r_bin_cnt != slbm_pkg::COUNT_MAX) begin
                r_bin_cnt <= r_bin_cnt + 1'b1;
            end
        end
    end

    slbm_fifo #(
        .WIDTH ($bits(slbm_pkg::t_item)),
        .DEPTH (slbm_pkg::IN_Q_DEPTH)
    ) u_in_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_in_valid),
        .o_wr_ready (o_in_ready),
        .i_wr_data  (w_item),
        .o_rd_valid (o_item_valid),
        .i_rd_ready (i_item_ready),
        .o_rd_data  (o_item)
    );

endmodule

@@ src/slbm_back.sv @@
// ---------------------------------------------------------------------------
// Spectrum log band bar meter: back end
// Band sequencer: edge update, saturating sum, clamped bar division, reports.
// ---------------------------------------------------------------------------
module slbm_back #(
    parameter int BANDS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    output logic                         o_item_ready,
    input  slbm_pkg::t_item              i_item,
    input  logic [slbm_pkg::START_W-1:0] i_start_center,
    input  logic [slbm_pkg::RATIO_W-1:0] i_band_ratio,
    input  logic [slbm_pkg::DIV_W-1:0]   i_amp_divisor,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output slbm_pkg::t_out_word          o_res_word
);

    localparam int IDX_W = $clog2(BANDS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_EDGE  = 6'b000100,
        S_CHECK = 6'b001000,
        S_DIV   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    slbm_pkg::t_item                 r_item, n_item;
    logic [slbm_pkg::CENTER_W-1:0]   r_center, n_center;
    logic [slbm_pkg::CENTER_W-1:0]   r_next_center, n_next_center;
    logic [slbm_pkg::EDGE_W-1:0]     r_edge, n_edge;
    logic [slbm_pkg::PROD_W-1:0]     r_prod, n_prod;
    logic [IDX_W-1:0]                r_idx, n_idx;
    logic [slbm_pkg::SUM_W-1:0]      r_sum, n_sum;
    logic [slbm_pkg::SUM_W-1:0]      r_rem, n_rem;
    logic [3:0]                      r_quot, n_quot;
    logic [1:0]                      r_step, n_step;
    logic [3:0]                      r_nres, n_nres;
    logic                            r_flush, n_flush;

    logic [slbm_pkg::DIV_W-1:0]      w_div;
    logic [3:0]                      w_height;
    logic [7:0]                      w_lit;
    logic                            w_open;

    assign w_div    = (i_amp_divisor == '0) ? slbm_pkg::DIV_W'(1) : i_amp_divisor;
    assign w_height = r_quot[3] ? slbm_pkg::H_MAX : r_quot;
    assign w_lit    = slbm_pkg::lit_rows(w_height);
    assign w_open   = (r_idx < IDX_W'(BANDS));

    always_comb begin
        o_res_word.band         = 3'(r_idx);
        o_res_word.height       = w_height;
        o_res_word.red_column   = w_lit & 8'((1 << slbm_pkg::RED_ROWS) - 1);
        o_res_word.green_column = w_lit & ~8'((1 << slbm_pkg::GREEN_SKIP) - 1);
        o_res_word.last_band    = (r_idx == IDX_W'(BANDS - 1));
    end

    always_comb begin
        logic [27:0]                v_next_raw;
        logic [slbm_pkg::CENTER_W-1:0] v_next;
        logic [slbm_pkg::CENTER_W:0]   v_esum;
        logic [slbm_pkg::SUM_W:0]      v_sum_ext;
        logic [slbm_pkg::SUM_W-1:0]    v_trial;
        logic                       v_take;

        n_state       = r_state;
        n_item        = r_item;
        n_center      = r_center;
        n_next_center = r_next_center;
        n_edge        = r_edge;
        n_prod        = r_prod;
        n_idx         = r_idx;
        n_sum         = r_sum;
        n_rem         = r_rem;
        n_quot        = r_quot;
        n_step        = r_step;
        n_nres        = r_nres;
        n_flush       = r_flush;
        o_item_ready  = 1'b0;
        o_res_valid   = 1'b0;
        v_take        = 1'b0;
        v_next_raw    = r_prod[slbm_pkg::PROD_W-1:slbm_pkg::RATIO_FRAC];
        v_next        = (v_next_raw[27:24] != '0) ? '1 : v_next_raw[23:0];
        v_esum        = {1'b0, r_center} + {1'b0, v_next};
        v_sum_ext     = {1'b0, r_sum} + {11'b0, r_item.magnitude};
        v_trial       = {10'b0, w_div} << r_step;

        case (r_state)
            S_IDLE: begin
                v_take = 1'b1;
            end
            S_MUL: begin
                n_prod  = r_center * i_band_ratio;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                n_next_center = v_next;
                n_edge        = v_esum[slbm_pkg::CENTER_W:slbm_pkg::EDGE_SHIFT];
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (w_open && (r_flush || (r_item.bin_num >= r_edge))) begin
                    n_rem   = r_sum;
                    n_quot  = '0;
                    n_step  = 2'd3;
                    n_state = S_DIV;
                end else if (!r_flush) begin
                    if (w_open && r_item.add_ok) begin
                        n_sum = v_sum_ext[slbm_pkg::SUM_W] ? slbm_pkg::SUM_MAX
                                                           : v_sum_ext[slbm_pkg::SUM_W-1:0];
                    end
                    if (r_item.last_bin) begin
                        n_flush = 1'b1;
                    end else begin
                        v_take = 1'b1;
                    end
                end else begin
                    n_flush = 1'b0;
                    n_idx   = '0;
                    n_sum   = '0;
                    v_take  = 1'b1;
                end
            end
            S_DIV: begin
                if (r_rem >= v_trial) begin
                    n_rem          = r_rem - v_trial;
                    n_quot[r_step] = 1'b1;
                end
                if (r_step == 2'd0) begin
                    n_state = S_EMIT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_EMIT: begin
                o_res_valid = (r_nres < slbm_pkg::MAX_RES);
                if (!o_res_valid || i_res_ready) begin
                    if (o_res_valid) begin
                        n_nres = r_nres + 1'b1;
                    end
                    n_idx    = r_idx + 1'b1;
                    n_sum    = '0;
                    n_center = r_next_center;
                    n_state  = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next bin straight from the queue
        if (v_take) begin
            o_item_ready = 1'b1;
            if (i_item_valid) begin
                n_item = i_item;
                n_nres = '0;
                if (i_item.bin_num == '0) begin
                    n_center = {1'b0, i_start_center};
                    n_state  = S_MUL;
                end else begin
                    n_state = S_CHECK;
                end
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_sum   <= '0;
            r_nres  <= '0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            r_nres  <= n_nres;
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item        <= n_item;
        r_center      <= n_center;
        r_next_center <= n_next_center;
        r_edge        <= n_edge;
        r_prod        <= n_prod;
        r_rem         <= n_rem;
        r_quot        <= n_quot;
        r_step        <= n_step;
    end

endmodule

@@ src/spectrum_log_band_bar_meter_unit.sv @@
// ---------------------------------------------------------------------------
// Spectrum log band bar meter
// Splits a frame of FFT magnitude bins into log-spaced bands, reports bars.
// ---------------------------------------------------------------------------
// Input channel: one magnitude bin per word, bin 0 first, last_bin on the
// final bin of the frame. Output channel: one word per closed band with its
// index, height 0..8 and the red and green pixel columns.
// Configuration: write start_center, band_ratio, noise_floor and
// amplitude_divisor through the write port while the block is idle.
// Sequencer: a bin that closes no band only passes the check state. The
// first bin of a frame first runs the edge update (multiply, then add and
// shift). Each closed band runs one check, four steps of the clamped bar
// division, one report and then the edge update for the next band.
// A four-word input queue and a four-word output queue decouple the sides.
// Reset: queues empty, band sequencer idle, registers at their defaults.
// When the receiver stalls the output queue fills, the sequencer holds its
// report, the input queue fills and then input ready drops.
// ---------------------------------------------------------------------------
`include "spectrum_log_band_bar_meter_unit_defines.svh"

module spectrum_log_band_bar_meter_unit #(
    parameter int FFT_SIZE = 1024,
    parameter int BANDS    = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  slbm_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output slbm_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_we,
    input  logic [slbm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [slbm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [slbm_pkg::START_W-1:0] r_start_center;
    logic [slbm_pkg::RATIO_W-1:0] r_band_ratio;
    logic [slbm_pkg::FLOOR_W-1:0] r_noise_floor;
    logic [slbm_pkg::DIV_W-1:0]   r_amp_divisor;

    logic                         w_item_valid, w_item_ready;
    slbm_pkg::t_item              w_item;
    logic                         w_res_valid, w_res_ready;
    slbm_pkg::t_out_word          w_res_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_center <= slbm_pkg::RST_START_CENTER;
            r_band_ratio   <= slbm_pkg::RST_BAND_RATIO;
            r_noise_floor  <= slbm_pkg::RST_NOISE_FLOOR;
            r_amp_divisor  <= slbm_pkg::RST_AMP_DIVISOR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                slbm_pkg::CFG_START_CENTER: begin
                    r_start_center <= i_cfg_wdata[slbm_pkg::START_W-1:0];
                end
                slbm_pkg::CFG_BAND_RATIO: begin
                    r_band_ratio <= i_cfg_wdata[slbm_pkg::RATIO_W-1:0];
                end
                slbm_pkg::CFG_NOISE_FLOOR: begin
                    r_noise_floor <= i_cfg_wdata[slbm_pkg::FLOOR_W-1:0];
                end
                slbm_pkg::CFG_AMP_DIVISOR: begin
                    r_amp_divisor <= i_cfg_wdata[slbm_pkg::DIV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    slbm_front #(
        .FFT_SIZE (FFT_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .i_noise_floor (r_noise_floor),
        .o_item_valid  (w_item_valid),
        .i_item_ready  (w_item_ready),
        .o_item        (w_item)
    );

    slbm_back #(
        .BANDS (BANDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (w_item_valid),
        .o_item_ready   (w_item_ready),
        .i_item         (w_item),
        .i_start_center (r_start_center),
        .i_band_ratio   (r_band_ratio),
        .i_amp_divisor  (r_amp_divisor),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res_word     (w_res_word)
    );

    slbm_fifo #(
        .WIDTH ($bits(slbm_pkg::t_out_word)),
        .DEPTH (slbm_pkg::OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_res_valid),
        .o_wr_ready (w_res_ready),
        .i_wr_data  (w_res_word),
        .o_rd_valid (o_out_valid),
        .i_rd_ready (i_out_ready),
        .o_rd_data  (o_out_word)
    );

    `SLBM_ASSERT_IMP(a_last_band_idx, o_out_valid && o_out_word.last_band, o_out_word.band == 3'(BANDS - 1), "last band flag on wrong band")
    `SLBM_ASSERT_IMP(a_height_max, o_out_valid, o_out_word.height <= slbm_pkg::H_MAX, "bar height above clamp")
    `SLBM_ASSERT_IMP(a_cols_overlap, o_out_valid, o_out_word.red_column[3:1] == o_out_word.green_column[3:1], "red and green rows disagree")
    `SLBM_ASSERT_NXT(a_res_hold, w_res_valid && !w_res_ready, w_res_valid, "band report dropped while queue full")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Spectrum log band bar meter: testbench
// Streams frames of magnitude bins through the meter under several register
// settings and checks every bar word against typed heights or a cycle-free predictor
// of the band split, the noise floor, the bar division and the pixel columns.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int NUM_BANDS = 8;
    localparam int FFT_BINS  = 1024;
    localparam int TOP_BIN   = FFT_BINS / 2 - 1;
    localparam int LIMIT     = 1_000_000;

    typedef struct packed {
        logic [slbm_pkg::MAG_W-1:0] mag;
        logic                       last;
        logic                       typed;
        logic [31:0]                hts;    // typed bar heights, band b in hts[4b+:4]
    } t_script_row;

    // a one-bin frame after reset, then two-bin frames, then one frame over the first bands
    localparam t_script_row BIN_SCRIPT [25] = '{
        '{24'hFFFFFF, 1'b1, 1'b1, 32'h0},
        '{24'hFFFFFF, 1'b0, 1'b0, 32'h0},
        '{24'hFFFFFF, 1'b1, 1'b1, 32'h8},
        '{24'd0,      1'b0, 1'b0, 32'h0},
        '{24'd10,     1'b1, 1'b1, 32'h0},
        '{24'd0,      1'b0, 1'b0, 32'h0},
        '{24'd7999,   1'b1, 1'b1, 32'h7},
        '{24'd0,      1'b0, 1'b0, 32'h0},
        '{24'd1000,   1'b1, 1'b1, 32'h1},
        '{24'd0,      1'b0, 1'b0, 32'h0},
        '{24'd8000,   1'b1, 1'b1, 32'h8},
        '{24'd123456, 1'b0, 1'b0, 32'h0},
        '{24'hFFFFFF, 1'b0, 1'b0, 32'h0},
        '{24'd3000,   1'b0, 1'b0, 32'h0},
        '{24'd500,    1'b0, 1'b0, 32'h0},
        '{24'd800000, 1'b0, 1'b0, 32'h0},
        '{24'd0,      1'b0, 1'b0, 32'h0},
        '{24'd11,     1'b0, 1'b0, 32'h0},
        '{24'hFFFFFF, 1'b0, 1'b0, 32'h0},
        '{24'd4000,   1'b0, 1'b0, 32'h0},
        '{24'd1,      1'b0, 1'b0, 32'h0},
        '{24'd2500,   1'b0, 1'b0, 32'h0},
        '{24'd7000000, 1'b0, 1'b0, 32'h0},
        '{24'd999,    1'b0, 1'b0, 32'h0},
        '{24'hFFFFFF, 1'b1, 1'b0, 32'h0}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            in_valid;
    logic                            in_ready;
    slbm_pkg::t_in_word              in_word;
    logic                            out_valid;
    logic                            out_ready;
    slbm_pkg::t_out_word             out_word;
    logic                            cfg_we;
    logic [slbm_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [slbm_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // predictor registers and state
    logic [slbm_pkg::START_W-1:0]    cfg_start;
    logic [slbm_pkg::RATIO_W-1:0]    cfg_ratio;
    logic [slbm_pkg::FLOOR_W-1:0]    cfg_floor;
    logic [slbm_pkg::DIV_W-1:0]      cfg_div;
    logic [slbm_pkg::BIN_W-1:0]      bin_cnt;
    int                              band_idx;
    logic [63:0]                     band_acc;
    logic [slbm_pkg::CENTER_W-1:0]   center;
    logic [slbm_pkg::EDGE_W-1:0]     edge_bin;

    slbm_pkg::t_out_word             pending_bars [$];
    slbm_pkg::t_out_word             step_bars [$];
    int                              bar_errors;
    int                              bars_seen;
    int                              bins_sent;
    int                              settings_run;
    int                              cycles = 0;
    logic                            tx_eager;
    logic                            rx_eager;

    spectrum_log_band_bar_meter_unit #(
        .FFT_SIZE(FFT_BINS),
        .BANDS(NUM_BANDS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_word(in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word(out_word),
        .i_cfg_we(cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [slbm_pkg::CENTER_W-1:0] next_center(
        logic [slbm_pkg::CENTER_W-1:0] c);
        logic [63:0] p;
        p = (64'(c) * 64'(cfg_ratio)) >> slbm_pkg::RATIO_FRAC;
        return (p > 64'hFFFFFF) ? 24'hFFFFFF : p[slbm_pkg::CENTER_W-1:0];
    endfunction

    function automatic logic [slbm_pkg::EDGE_W-1:0] upper_edge(
        logic [slbm_pkg::CENTER_W-1:0] c);
        logic [63:0] e;
        e = (64'(c) + 64'(next_center(c))) >> slbm_pkg::EDGE_SHIFT;
        return (e > 64'd1023) ? 10'd1023 : e[slbm_pkg::EDGE_W-1:0];
    endfunction

    function automatic slbm_pkg::t_out_word make_bar(int b, int h);
        slbm_pkg::t_out_word v;
        logic                lit;
        for (int r = 0; r < 8; r++) begin
            lit = (r >= slbm_pkg::BAR_HEIGHT - h);
            v.red_column[r]   = lit && (r < slbm_pkg::RED_ROWS);
            v.green_column[r] = lit && (r >= slbm_pkg::GREEN_SKIP);
        end
        v.band      = 3'(b);
        v.height    = 4'(h);
        v.last_band = (b == NUM_BANDS - 1);
        return v;
    endfunction

    task automatic close_bar();
        logic [63:0] q;
        logic [63:0] dv;
        dv = (cfg_div == '0) ? 64'd1 : 64'(cfg_div);
        q  = band_acc / dv;
        if (q > 64'(slbm_pkg::BAR_HEIGHT))
            q = 64'(slbm_pkg::BAR_HEIGHT);
        if (step_bars.size() < 8)
            step_bars.push_back(make_bar(band_idx, int'(q)));
        band_acc = '0;
        band_idx++;
        center   = next_center(center);
        edge_bin = upper_edge(center);
    endtask

    task automatic meter_step(input slbm_pkg::t_in_word w);
        logic [slbm_pkg::BIN_W-1:0] j;
        j = bin_cnt;
        step_bars.delete();
        if (j == '0 && band_idx == 0) begin
            center   = slbm_pkg::CENTER_W'(cfg_start);
            edge_bin = upper_edge(center);
        end
        while (band_idx < NUM_BANDS && j >= edge_bin)
            close_bar();
        if (band_idx < NUM_BANDS && j >= 1 && j < TOP_BIN && w.magnitude > cfg_floor) begin
            band_acc = band_acc + 64'(w.magnitude);
            if (band_acc > 64'(slbm_pkg::SUM_MAX))
                band_acc = 64'(slbm_pkg::SUM_MAX);
        end
        if (w.last_bin) begin
            while (band_idx < NUM_BANDS)
                close_bar();
            bin_cnt  = '0;
            band_idx = 0;
            band_acc = '0;
            center   = slbm_pkg::CENTER_W'(cfg_start);
            edge_bin = upper_edge(center);
        end else begin
            bin_cnt = (j < slbm_pkg::COUNT_MAX) ? j + 1'b1 : slbm_pkg::COUNT_MAX;
        end
    endtask

    task automatic send_bin(input logic [slbm_pkg::MAG_W-1:0] mag, input logic last,
                            input logic typed, input logic [31:0] hts);
        int                 gap;
        slbm_pkg::t_in_word w;
        gap = tx_eager ? 0 : $urandom_range(0, 8);
        w.magnitude = mag;
        w.last_bin  = last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!in_ready);
        meter_step(w);
        if (typed) begin
            for (int b = 0; b < NUM_BANDS; b++)
                pending_bars.push_back(make_bar(b, int'(hts[4*b +: 4])));
        end else begin
            foreach (step_bars[k])
                pending_bars.push_back(step_bars[k]);
        end
        bins_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_bars.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic put_reg(input slbm_pkg::t_cfg_reg r,
                           input logic [slbm_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge i_clk);
        case (r)
            slbm_pkg::CFG_START_CENTER: cfg_start = v[slbm_pkg::START_W-1:0];
            slbm_pkg::CFG_BAND_RATIO:   cfg_ratio = v[slbm_pkg::RATIO_W-1:0];
            slbm_pkg::CFG_NOISE_FLOOR:  cfg_floor = v[slbm_pkg::FLOOR_W-1:0];
            slbm_pkg::CFG_AMP_DIVISOR:  cfg_div   = v[slbm_pkg::DIV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_regs(input int s, input int r, input int f, input int d);
        put_reg(slbm_pkg::CFG_START_CENTER, 24'(s));
        put_reg(slbm_pkg::CFG_BAND_RATIO, 24'(r));
        put_reg(slbm_pkg::CFG_NOISE_FLOOR, 24'(f));
        put_reg(slbm_pkg::CFG_AMP_DIVISOR, 24'(d));
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [slbm_pkg::MAG_W-1:0] rand_mag();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return cfg_floor;
            3: return (cfg_floor == '1) ? cfg_floor : cfg_floor + 1'b1;
            4, 5: return slbm_pkg::MAG_W'($urandom_range(0, 4000));
            default: return slbm_pkg::MAG_W'($urandom());
        endcase
    endfunction

    // bar word sink with random stalls
    initial begin : bar_sink
        int                  gap;
        int                  run;
        slbm_pkg::t_out_word got;
        slbm_pkg::t_out_word want;
        out_ready = 1'b0;
        run = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (run == 0) begin
                rx_eager = ($urandom_range(0, 3) == 0);
                run = 16;
            end
            run--;
            gap = rx_eager ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            got = out_word;
            bars_seen++;
            if (pending_bars.size() == 0) begin
                bar_errors++;
                if (bar_errors <= 10)
                    $display("unexpected bar word: band %0d height %0d red %h green %h last %b",
                             got.band, got.height, got.red_column, got.green_column,
                             got.last_band);
            end else begin
                want = pending_bars.pop_front();
                if (got.band !== want.band || got.height !== want.height ||
                    got.red_column !== want.red_column ||
                    got.green_column !== want.green_column ||
                    got.last_band !== want.last_band) begin
                    bar_errors++;
                    if (bar_errors <= 10)
                        $display({"bar word mismatch: exp band %0d h %0d red %h green %h ",
                                  "last %b, got band %0d h %0d red %h green %h last %b"},
                                 want.band, want.height, want.red_column,
                                 want.green_column, want.last_band, got.band,
                                 got.height, got.red_column, got.green_column,
                                 got.last_band);
                end
            end
        end
    end

    initial begin : stimulus
        int n;
        int len;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        cfg_we       = 1'b0;
        cfg_addr     = slbm_pkg::CFG_START_CENTER;
        cfg_wdata    = '0;
        bar_errors   = 0;
        bars_seen    = 0;
        bins_sent    = 0;
        settings_run = 1;
        tx_eager     = 1'b0;
        cfg_start    = slbm_pkg::RST_START_CENTER;
        cfg_ratio    = slbm_pkg::RST_BAND_RATIO;
        cfg_floor    = slbm_pkg::RST_NOISE_FLOOR;
        cfg_div      = slbm_pkg::RST_AMP_DIVISOR;
        bin_cnt      = '0;
        band_idx     = 0;
        band_acc     = '0;
        center       = slbm_pkg::CENTER_W'(slbm_pkg::RST_START_CENTER);
        edge_bin     = upper_edge(center);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (BIN_SCRIPT[i])
            send_bin(BIN_SCRIPT[i].mag, BIN_SCRIPT[i].last, BIN_SCRIPT[i].typed,
                     BIN_SCRIPT[i].hts);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_regs(slbm_pkg::RST_START_CENTER, slbm_pkg::RST_BAND_RATIO,
                              slbm_pkg::RST_NOISE_FLOOR, slbm_pkg::RST_AMP_DIVISOR);
                1: write_regs(24'h7FFFFF, 24'hFFFF, 0, 1);
                2: write_regs(0, 4096, 24'hFFFFFF, 24'hFFFFFF);
                3: write_regs(655360, 3000, 100, 0);    // shrinking centers, divisor 0
                default: write_regs($urandom_range(4096, 300000), $urandom_range(4096, 12000),
                                    $urandom_range(0, 500), $urandom_range(1, 20000));
            endcase
            n = 0;
            while (n < 34) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 16);
                tx_eager = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len; k++)
                    send_bin(rand_mag(), k == len - 1, 1'b0, 32'h0);
                n += len;
            end
            settle();
        end

        $display("Sent %0d magnitude bins under %0d register settings, %0d bar words checked",
                 bins_sent, settings_run, bars_seen);
        if (bar_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/slbm_pkg.sv
src/slbm_fifo.sv
src/slbm_front.sv
src/slbm_back.sv
src/spectrum_log_band_bar_meter_unit.sv
test/tb_top.sv
